@@ src/alle_pkg.sv @@
package alle_pkg;

    typedef enum logic [2:0] {
        ACT_INS_HEAD   = 3'd0,
        ACT_INS_TAIL   = 3'd1,
        ACT_INS_SORTED = 3'd2,
        ACT_DELETE     = 3'd3,
        ACT_CHANGE     = 3'd4,
        ACT_EXTRACT    = 3'd5
    } action_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch request, start walk at head
        logic rd;        // read node at cursor (values and links)
        logic advance;   // prev <= cur, cur <= link
        logic restart;   // cursor back to head, steps cleared
        logic track_max; // update running maximum from current value
        logic key_max;   // replace key with running maximum
        logic do_ins;    // perform insert linking
        logic do_del;    // unlink current node
        logic do_chg;    // rewrite current value
        logic respond;   // drive result
        logic ok;
    } alle_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cur_null;
        logic steps_done;
        logic val_eq;
        logic key_gt;
        logic free_empty;
        logic found_max;
    } alle_sts_t;

endpackage

@@ src/alle_datapath.sv @@
module alle_datapath #(
    parameter int NODES = 16,
    parameter int LW    = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  alle_pkg::action_t   action,
    input  logic signed [31:0]  key_value,
    input  logic signed [31:0]  replacement,
    input  alle_pkg::alle_cmd_t cmd,
    output alle_pkg::alle_sts_t sts,
    output logic                ok,
    output logic signed [31:0]  max_value,
    output logic [LW-1:0]       node_count,
    output logic                is_full,
    output logic                is_empty,
    output logic                init_done
);
    import alle_pkg::*;

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam logic [LW-1:0] LNULL = LW'(NODES);

    logic signed [31:0] vmem [NODES];
    logic [LW-1:0]      lmem [NODES];

    logic [LW-1:0] head_reg, free_reg, count_reg;
    logic [LW-1:0] cur_reg, prev_reg, steps_reg;
    logic signed [31:0] key_reg, repl_reg, maxv_reg, rval_reg;
    logic [LW-1:0] rlink_reg;
    logic found_reg;
    logic [LW-1:0] init_reg;
    action_t act_reg;
    logic ok_reg;
    logic signed [31:0] mout_reg;

    // fix cycle needs the slot taken by the insert
    logic [LW-1:0] slot_reg;

    logic [IW-1:0] cur_idx, prev_idx, free_idx;
    assign cur_idx  = cur_reg[IW-1:0];
    assign prev_idx = prev_reg[IW-1:0];
    assign free_idx = free_reg[IW-1:0];

    logic cur_null;
    assign cur_null = (cur_reg >= LNULL);
    assign init_done = (init_reg == LNULL);

    assign sts.cur_null   = cur_null;
    assign sts.steps_done = (steps_reg >= LNULL);
    assign sts.val_eq     = (rval_reg == key_reg);
    assign sts.key_gt     = (key_reg > rval_reg);
    assign sts.free_empty = (free_reg >= LNULL);
    assign sts.found_max  = found_reg;

    // link memory: init sweep after reset, then one write per cycle
    logic          lw_en;
    logic [IW-1:0] lw_addr;
    logic [LW-1:0] lw_data;
    always_comb
    begin
        lw_en   = 1'b0;
        lw_addr = '0;
        lw_data = '0;
        if (!init_done)
        begin
            lw_en   = 1'b1;
            lw_addr = init_reg[IW-1:0];
            lw_data = (init_reg == LNULL - LW'(1)) ? LNULL : init_reg + LW'(1);
        end
        else if (cmd.do_ins)
        begin
            lw_en = 1'b1;
            if (act_reg == ACT_INS_TAIL)
            begin
                if (prev_reg >= LNULL)
                begin
                    lw_addr = free_idx;
                    lw_data = LNULL;
                end
                else
                begin
                    lw_addr = prev_idx;
                    lw_data = free_reg;
                end
            end
            else if (act_reg == ACT_INS_SORTED && prev_reg < LNULL)
            begin
                lw_addr = prev_idx;
                lw_data = free_reg;
            end
            else
            begin
                lw_addr = free_idx;
                lw_data = (act_reg == ACT_INS_HEAD) ? head_reg : cur_reg;
            end
        end
        else if (cmd.do_del && prev_reg < LNULL)
        begin
            lw_en   = 1'b1;
            lw_addr = prev_idx;
            lw_data = rlink_reg;
        end
        else if (cmd.do_del)
        begin
            lw_en   = 1'b1;
            lw_addr = cur_idx;
            lw_data = free_reg;
        end
    end

    // second link write of a non-head tail or sorted insert, or of a non-head
    // delete, is issued by the follow-up "fix" cycle through the same port
    logic fix_reg;

    always_ff @(posedge clk)
    begin
        if (lw_en)
            lmem[lw_addr] <= lw_data;
        else if (fix_reg)
        begin
            if (act_reg == ACT_INS_TAIL)
                lmem[slot_reg[IW-1:0]] <= LNULL;
            else if (act_reg == ACT_INS_SORTED)
                lmem[slot_reg[IW-1:0]] <= cur_reg;
            else
                lmem[cur_idx] <= free_reg;
        end
        if (cmd.do_ins)
            vmem[free_idx] <= key_reg;
        else if (cmd.do_chg)
            vmem[cur_idx] <= repl_reg;
        if (cmd.rd)
        begin
            rval_reg  <= vmem[cur_idx];
            rlink_reg <= lmem[cur_idx];
        end
    end

    logic fix_next;
    always_comb
    begin
        fix_next = 1'b0;
        if (cmd.do_ins && act_reg == ACT_INS_TAIL && prev_reg < LNULL)
            fix_next = 1'b1;
        if (cmd.do_ins && act_reg == ACT_INS_SORTED && prev_reg < LNULL)
            fix_next = 1'b1;
        if (cmd.do_del && prev_reg < LNULL)
            fix_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg  <= '0;
            head_reg  <= LNULL;
            free_reg  <= '0;
            count_reg <= '0;
            fix_reg   <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            fix_reg <= fix_next;
            if (!init_done)
                init_reg <= init_reg + LW'(1);
            if (cmd.do_ins)
            begin
                count_reg <= count_reg + LW'(1);
                free_reg  <= lmem[free_idx];
                if (act_reg == ACT_INS_HEAD ||
                    (act_reg != ACT_INS_HEAD && prev_reg >= LNULL))
                    head_reg <= free_reg;
            end
            if (cmd.do_del)
            begin
                count_reg <= count_reg - LW'(1);
                if (prev_reg >= LNULL)
                begin
                    head_reg <= rlink_reg;
                    free_reg <= cur_reg;
                end
            end
            if (fix_reg && act_reg != ACT_INS_TAIL && act_reg != ACT_INS_SORTED)
                free_reg <= cur_reg;
            if (cmd.respond)
                ok_reg <= cmd.ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= action;
            key_reg   <= key_value;
            repl_reg  <= replacement;
            maxv_reg  <= -32'sd1;
            found_reg <= 1'b0;
        end
        if (cmd.load || cmd.restart)
        begin
            cur_reg   <= head_reg;
            prev_reg  <= LNULL;
            steps_reg <= '0;
        end
        else if (cmd.advance)
        begin
            prev_reg  <= cur_reg;
            cur_reg   <= rlink_reg;
            steps_reg <= steps_reg + LW'(1);
        end
        if (cmd.track_max && rval_reg > maxv_reg)
        begin
            maxv_reg  <= rval_reg;
            found_reg <= 1'b1;
        end
        if (cmd.key_max)
            key_reg <= maxv_reg;
        if (cmd.do_ins)
            slot_reg <= free_reg;
        if (cmd.respond)
            mout_reg <= (act_reg == ACT_EXTRACT) ? maxv_reg : 32'sd0;
    end

    assign ok         = ok_reg;
    assign max_value  = mout_reg;
    assign node_count = count_reg;
    assign is_full    = (free_reg >= LNULL);
    assign is_empty   = (head_reg >= LNULL);

endmodule

@@ src/alle_ctrl.sv @@
module alle_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  alle_pkg::action_t   action,
    input  alle_pkg::alle_sts_t sts,
    input  logic                init_done,
    output alle_pkg::alle_cmd_t cmd,
    output logic                busy,
    output logic                done
);
    import alle_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD    = 9'b000000010,
        S_EVAL  = 9'b000000100,
        S_FIX   = 9'b000001000,
        S_RESP  = 9'b000010000,
        S_MRD   = 9'b000100000,
        S_MEVAL = 9'b001000000,
        S_MSET  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    action_t act_reg;
    logic ok_reg, ok_next;

    always_comb
    begin
        state_next = state_reg;
        ok_next    = ok_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start && init_done)
                begin
                    cmd.load = 1'b1;
                    ok_next  = 1'b0;
                    if (action == ACT_EXTRACT)
                        state_next = S_MRD;
                    else if (action == ACT_INS_HEAD)
                        state_next = S_EVAL;
                    else if (action > ACT_EXTRACT)
                        state_next = S_RESP;
                    else
                        state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd     = !sts.cur_null;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_RESP;
                case (act_reg)
                    ACT_INS_HEAD:
                        if (!sts.free_empty)
                        begin
                            cmd.do_ins = 1'b1;
                            ok_next    = 1'b1;
                        end
                    ACT_INS_TAIL:
                        if (sts.free_empty)
                            ;
                        else if (sts.cur_null || sts.steps_done)
                        begin
                            cmd.do_ins = 1'b1;
                            ok_next    = 1'b1;
                            state_next = S_FIX;
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                            state_next  = S_RD;
                        end
                    ACT_INS_SORTED:
                        if (sts.free_empty)
                            ;
                        else if (!sts.cur_null && !sts.steps_done && sts.key_gt)
                        begin
                            cmd.advance = 1'b1;
                            state_next  = S_RD;
                        end
                        else if (!sts.cur_null && sts.val_eq)
                            ;
                        else
                        begin
                            cmd.do_ins = 1'b1;
                            ok_next    = 1'b1;
                            state_next = S_FIX;
                        end
                    ACT_DELETE, ACT_CHANGE, ACT_EXTRACT:
                        if (sts.cur_null || sts.steps_done)
                            ;
                        else if (sts.val_eq)
                        begin
                            ok_next = 1'b1;
                            if (act_reg == ACT_CHANGE)
                                cmd.do_chg = 1'b1;
                            else
                            begin
                                cmd.do_del = 1'b1;
                                state_next = S_FIX;
                            end
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                            state_next  = S_RD;
                        end
                    default: ;
                endcase
            end
            S_FIX:
                state_next = S_RESP;
            S_MRD:
            begin
                cmd.rd     = !sts.cur_null;
                state_next = S_MEVAL;
            end
            S_MEVAL:
            begin
                if (sts.cur_null || sts.steps_done)
                    state_next = S_MSET;
                else
                begin
                    cmd.track_max = 1'b1;
                    cmd.advance   = 1'b1;
                    state_next    = S_MRD;
                end
            end
            S_MSET:
            begin
                if (sts.found_max)
                begin
                    cmd.key_max = 1'b1;
                    cmd.restart = 1'b1;
                    state_next  = S_RD;
                end
                else
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                cmd.respond = 1'b1;
                cmd.ok      = ok_reg;
                state_next  = S_OUT;
            end
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ok_reg    <= 1'b0;
            act_reg   <= ACT_INS_HEAD;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
            if (cmd.load)
                act_reg <= action;
        end
    end

    assign busy = (state_reg != S_IDLE) || !init_done;
    assign done = (state_reg == S_OUT);

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.do_ins && cmd.do_del)) else $error("insert and delete together");
    a_done_after_resp: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_RESP)) else $error("done without respond");
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE) else $error("load while busy");

endmodule

@@ src/array_linked_list_engine.sv @@
// channel  | signals                                | handshake
// request  | action, key_value, replacement         | start high while busy low
// result   | ok, max_value, node_count, is_full,    | done, one cycle, no stall
//          | is_empty                               |
// After reset a sweep over all NODE_COUNT nodes builds the free chain; busy is high.
// After acceptance a walk reads and then compares each node in turn before
// done rises; head insert skips the walk and unused codes go straight to result.
// Extract max walks twice if a maximum is found: to find it, then to unlink it.
// Results cannot be stalled; done pulses once per accepted request.
module array_linked_list_engine #(
    parameter int NODE_COUNT = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                action,
    input  logic signed [31:0]        key_value,
    input  logic signed [31:0]        replacement,
    output logic                      done,
    output logic                      ok,
    output logic signed [31:0]        max_value,
    output logic [$clog2(NODE_COUNT+1)-1:0] node_count,
    output logic                      is_full,
    output logic                      is_empty
);
    import alle_pkg::*;

    localparam int LW = $clog2(NODE_COUNT + 1);

    alle_cmd_t cmd;
    alle_sts_t sts;
    logic      init_done;
    action_t   act;

    assign act = action_t'(action);

    alle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .action    (act),
        .sts       (sts),
        .init_done (init_done),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    alle_datapath #(.NODES(NODE_COUNT), .LW(LW)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .action      (act),
        .key_value   (key_value),
        .replacement (replacement),
        .cmd         (cmd),
        .sts         (sts),
        .ok          (ok),
        .max_value   (max_value),
        .node_count  (node_count),
        .is_full     (is_full),
        .is_empty    (is_empty),
        .init_done   (init_done)
    );

endmodule
